[sv/agm_pkg.sv]
// Shared constants and types of the AGM sequence generator.
// No dependencies; used by agm_sqrt and agm_sequence_generator_core.
package agm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned REM_W      = DATA_W + 3;
  localparam int unsigned SQ_STEPS   = DATA_W;
  localparam int unsigned SQ_CNT_W   = $clog2(SQ_STEPS);
  localparam int unsigned TERM_W     = 6;
  localparam int unsigned ADDR_W     = 3;

  localparam int unsigned MAX_STEPS  = 32;
  localparam int unsigned RESULT_CAP = 32;
  localparam int unsigned LIMIT_RAW  = (MAX_STEPS > RESULT_CAP) ? RESULT_CAP : MAX_STEPS;
  localparam int unsigned LIMIT      = (LIMIT_RAW < 2) ? 2 : LIMIT_RAW;
  localparam logic [TERM_W-1:0] LIMIT_M1 = TERM_W'(LIMIT - 1);

  localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

  localparam logic [ADDR_W-3:0] REG_PRECISION = '0;
  localparam logic [DATA_W-1:0] PRECISION_RST = DATA_W'(1);

  typedef struct packed {
    logic start;
  } sq_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_sts_t;

endpackage

[sv/agm_sqrt.sv]
// Bit-serial unit: shift-add product of two 32-bit operands, then a
// restoring square root of the 64-bit product, one result bit per cycle.
// Depends on agm_pkg.
module agm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  agm_pkg::sq_req_t              req,
  input  logic [agm_pkg::DATA_W-1:0]    op_a,
  input  logic [agm_pkg::DATA_W-1:0]    op_b,
  output agm_pkg::sq_sts_t              sts,
  output logic [agm_pkg::DATA_W-1:0]    root
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT} sq_state_t;

  sq_state_t                         state_r;
  logic [agm_pkg::SQ_CNT_W-1:0]      cnt_r;
  logic [agm_pkg::PROD_W-1:0]        p_r;
  logic [agm_pkg::DATA_W-1:0]        a_r;
  logic [agm_pkg::REM_W-1:0]         rem_r;
  logic [agm_pkg::DATA_W-1:0]        root_r;
  logic                              done_r;

  logic [agm_pkg::DATA_W:0]          mul_sum;
  logic [agm_pkg::REM_W-1:0]         rem_sh;
  logic [agm_pkg::REM_W-1:0]         trial;
  logic                              ge;

  always_comb begin
    mul_sum = {1'b0, p_r[agm_pkg::PROD_W-1:agm_pkg::DATA_W]}
            + {1'b0, (p_r[0] ? a_r : '0)};
    rem_sh  = {rem_r[agm_pkg::REM_W-3:0], p_r[agm_pkg::PROD_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            p_r     <= {{agm_pkg::DATA_W{1'b0}}, op_b};
            a_r     <= op_a;
            cnt_r   <= '0;
            done_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_r   <= {mul_sum, p_r[agm_pkg::DATA_W-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == agm_pkg::SQ_LAST) begin
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          p_r    <= {p_r[agm_pkg::PROD_W-3:0], 2'b00};
          rem_r  <= ge ? (rem_sh - trial) : rem_sh;
          root_r <= {root_r[agm_pkg::DATA_W-2:0], ge};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == agm_pkg::SQ_LAST) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sts.busy = (state_r != S_IDLE);
  assign sts.done = done_r;
  assign root     = root_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && state_r == S_IDLE) |=> (state_r == S_MUL && !done_r))
    else $error("sqrt unit did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_IDLE || $past(req.start)))
    else $error("sqrt done while busy");
  a_mul_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == agm_pkg::SQ_LAST) |=> (state_r == S_ROOT && cnt_r == '0))
    else $error("multiply phase miscounted");

endmodule

[sv/agm_sequence_generator_core.sv]
// AGM sequence generator top level: APB register, sequencer, output register.
// Depends on agm_pkg and agm_sqrt.
// Term 0 is registered and presented in the cycle after the item is taken;
// each later term waits for a shift-add multiply and then a bit-serial root
// in the agm_sqrt unit, and is loaded once that unit is done and the output
// register is free. Reset: rst_n, sync.
module agm_sequence_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_start_a,
  input  logic [31:0]                   in_start_b,
  input  logic signed [31:0]            in_start_c,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_term_index,
  output logic [31:0]                   out_term_a,
  output logic [31:0]                   out_term_b,
  output logic signed [31:0]            out_term_c,
  output logic                          out_last_term,
  output logic                          out_cut_short,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [agm_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic {S_IDLE, S_CALC} state_t;

  state_t                           state_r;
  logic [agm_pkg::DATA_W-1:0]       precision_r;
  logic [agm_pkg::DATA_W-1:0]       cur_a_r;
  logic [agm_pkg::DATA_W-1:0]       cur_b_r;
  logic [agm_pkg::TERM_W-1:0]       n_r;
  logic                             out_valid_r;
  logic [agm_pkg::TERM_W-1:0]       out_index_r;
  logic [agm_pkg::DATA_W-1:0]       out_a_r;
  logic [agm_pkg::DATA_W-1:0]       out_b_r;
  logic [agm_pkg::DATA_W-1:0]       out_c_r;
  logic                             out_last_r;
  logic                             out_cut_r;

  logic                             out_free;
  logic                             in_accept;
  logic                             step_load;
  logic                             cfg_wr;
  logic [agm_pkg::DATA_W:0]         sum;
  logic [agm_pkg::DATA_W:0]         diff;
  logic [agm_pkg::DATA_W-1:0]       new_a;
  logic [agm_pkg::DATA_W-1:0]       new_c;
  logic [agm_pkg::DATA_W-1:0]       mag;
  logic                             conv;
  logic [agm_pkg::TERM_W-1:0]       n_nxt;
  logic                             last_nxt;

  agm_pkg::sq_req_t                 sq_req;
  agm_pkg::sq_sts_t                 sq_sts;
  logic [agm_pkg::DATA_W-1:0]       sq_a;
  logic [agm_pkg::DATA_W-1:0]       sq_b;
  logic [agm_pkg::DATA_W-1:0]       sq_root;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = !(state_r == S_IDLE && out_free);
    in_accept = in_valid && !in_stall;
    cfg_wr    = psel && penable && pwrite
             && (paddr[agm_pkg::ADDR_W-1:2] == agm_pkg::REG_PRECISION);

    sum   = {1'b0, cur_a_r} + {1'b0, cur_b_r};
    diff  = {1'b0, cur_a_r} - {1'b0, cur_b_r};
    new_a = sum[agm_pkg::DATA_W:1];
    new_c = diff[agm_pkg::DATA_W:1];
    mag   = new_c[agm_pkg::DATA_W-1] ? (~new_c + 1'b1) : new_c;
    conv  = !(mag > precision_r);

    n_nxt    = n_r + 1'b1;
    last_nxt = conv || (n_nxt == agm_pkg::LIMIT_M1);
    step_load = (state_r == S_CALC) && sq_sts.done && out_free;

    sq_req.start = in_accept || (step_load && !last_nxt);
    sq_a         = in_accept ? in_start_a : new_a;
    sq_b         = in_accept ? in_start_b : sq_root;
  end

  agm_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .op_a (sq_a),
    .op_b (sq_b),
    .sts  (sq_sts),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      precision_r <= agm_pkg::PRECISION_RST;
      n_r         <= '0;
    end else begin
      if (cfg_wr) begin
        precision_r <= pwdata;
      end
      priority if (in_accept) begin
        cur_a_r     <= in_start_a;
        cur_b_r     <= in_start_b;
        n_r         <= '0;
        out_index_r <= '0;
        out_a_r     <= in_start_a;
        out_b_r     <= in_start_b;
        out_c_r     <= in_start_c;
        out_last_r  <= 1'b0;
        out_cut_r   <= 1'b0;
        out_valid_r <= 1'b1;
        state_r     <= S_CALC;
      end else if (step_load) begin
        cur_a_r     <= new_a;
        cur_b_r     <= sq_root;
        n_r         <= n_nxt;
        out_index_r <= n_nxt;
        out_a_r     <= new_a;
        out_b_r     <= sq_root;
        out_c_r     <= new_c;
        out_last_r  <= last_nxt;
        out_cut_r   <= !conv;
        out_valid_r <= 1'b1;
        state_r     <= last_nxt ? S_IDLE : S_CALC;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_term_index = out_index_r;
  assign out_term_a     = out_a_r;
  assign out_term_b     = out_b_r;
  assign out_term_c     = out_c_r;
  assign out_last_term  = out_last_r;
  assign out_cut_short  = out_cut_r && out_last_r;
  assign pready         = 1'b1;
  assign prdata         = (paddr[agm_pkg::ADDR_W-1:2] == agm_pkg::REG_PRECISION)
                        ? precision_r : '0;

  a_first_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_valid && out_term_index == '0 && !out_last_term))
    else $error("term zero not presented after item taken");
  a_cut_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cut_short) |-> (out_term_index == agm_pkg::LIMIT_M1))
    else $error("cut_short away from the term limit");
  a_idle_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sq_sts.busy)
    else $error("sqrt unit busy while sequencer idle");
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_load && last_nxt) |=> (state_r == S_IDLE && out_last_term))
    else $error("last term did not end the sequence");

endmodule
